[sv/hgr_pkg.sv]
// Shared types and constants for the homeostatic gain regulator.
// Used by every module of the block; depends on nothing.
package hgr_pkg;

   localparam int HGR_CHAN_DEPTH = 64;

   localparam int CMD_W      = 2;
   localparam int CHAN_W     = 6;
   localparam int DATA_W     = 32;
   localparam int DT_W       = 24;
   localparam int ITC_W      = 24;
   localparam int ACTIVE_W   = 7;
   localparam int INTEG_W    = 48;
   localparam int GAIN_W     = 20;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_TDATA_W = 96;   // 94 bits of fields, padded to 12 bytes
   localparam int RSP_TDATA_W = 56;   // 52 bits of fields, padded to 7 bytes

   localparam logic [GAIN_W-1:0]   GAIN_ONE     = 20'd65536;
   localparam logic [GAIN_W-1:0]   GAIN_MIN     = 20'd6554;
   localparam logic [GAIN_W-1:0]   GAIN_MAX     = 20'd655360;
   localparam logic [12:0]         TENTH_Q16    = 13'd6554;
   localparam logic [ITC_W-1:0]    ITC_RESET    = 24'd65536;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_LEVEL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_TAU      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_CHANS = 2'd2;

   typedef enum logic [1:0] {
      CMD_UPDATE     = 2'd0,
      CMD_APPLY      = 2'd1,
      CMD_RESET_CHAN = 2'd2,
      CMD_RESET_ALL  = 2'd3
   } hgr_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_ACT,
      ST_SMOOTH,
      ST_MUL_ERR,
      ST_INTEG,
      ST_MUL_GAIN,
      ST_FINISH,
      ST_CLEAR
   } hgr_state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  smoothed;
      logic signed [INTEG_W-1:0] integral;
      logic [GAIN_W-1:0]         gain;
   } hgr_entry_type;

   localparam hgr_entry_type ENTRY_RESET = '{smoothed: '0, integral: '0, gain: GAIN_ONE};

   // sequencer view handed to the datapath
   typedef struct packed {
      hgr_state_type state;
      hgr_cmd_type   cmd;
      logic          chan_ok;
      logic          dt_zero;
      logic          accept;
      logic          finish;
   } hgr_ctl_type;

endpackage

[sv/hgr_table.sv]
// Channel state memory: one write port, one read port, registered read data.
// Depends on hgr_pkg for the entry layout.
module hgr_table import hgr_pkg::*; #(
   parameter int CHAN_DEPTH = HGR_CHAN_DEPTH
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [((CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1)-1:0] wr_addr,
   input  hgr_entry_type wr_data,
   input  logic [((CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1)-1:0] rd_addr,
   output hgr_entry_type rd_data
);

   hgr_entry_type mem [CHAN_DEPTH];
   hgr_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/hgr_arith.sv]
// Fixed-point datapath: smoothing, error integration, gain and apply scaling,
// plus the result register. Depends on hgr_pkg; steered by hgr_ctrl.
module hgr_arith import hgr_pkg::*; (
   input  logic                     clock,
   input  hgr_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] req_activity,
   input  logic [DT_W-1:0]          req_time_step,
   input  logic signed [DATA_W-1:0] req_sample_value,
   input  logic signed [DATA_W-1:0] target_level,
   input  logic [ITC_W-1:0]         inv_tau,
   input  hgr_entry_type            rd_data,
   output hgr_entry_type            wr_data,
   output logic                     rsp_ok,
   output logic signed [DATA_W-1:0] rsp_scaled_value,
   output logic [GAIN_W-1:0]        rsp_gain
);

   localparam logic signed [49:0] GMIN_S = 50'(GAIN_MIN);
   localparam logic signed [49:0] GMAX_S = 50'(GAIN_MAX);

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [49:0] v);
      if (v[49:31] == '0 || v[49:31] == '1) begin
         return v[31:0];
      end
      return v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [49:0] v);
      if (v[49:47] == '0 || v[49:47] == '1) begin
         return v[47:0];
      end
      return v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
   endfunction

   logic signed [DATA_W-1:0]  act_ff, sample_ff, smooth_ff, smooth_in;
   logic [DT_W-1:0]           dt_ff;
   logic [31:0]               alpha_ff;
   logic [64:0]               prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic                      ok_ff, ok_in;
   logic signed [DATA_W-1:0]  scaled_ff, scaled_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;

   logic [47:0]        alpha_full;
   logic signed [32:0] diff, err;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic [47:0]        integ_mag;
   logic [49:0]        q_ext;
   logic signed [49:0] q_s, gsum;
   logic [GAIN_W-1:0]  g_new;

   assign alpha_full = dt_ff * inv_tau;
   assign diff = {act_ff[31], act_ff} - {rd_data.smoothed[31], rd_data.smoothed};
   assign err  = {target_level[31], target_level} - {smooth_ff[31], smooth_ff};
   assign integ_mag = integ_ff[47] ? 48'(-integ_ff) : 48'(integ_ff);

   // product magnitude after the Q16 shift, signed back (truncates toward zero)
   assign q_ext = {1'b0, prod_ff[64:16]};
   assign q_s   = neg_ff ? -$signed(q_ext) : $signed(q_ext);
   assign gsum  = 50'sd65536 + q_s;

   always_comb begin
      if (gsum < GMIN_S) begin
         g_new = GAIN_MIN;
      end else if (gsum > GMAX_S) begin
         g_new = GAIN_MAX;
      end else begin
         g_new = gsum[GAIN_W-1:0];
      end
   end

   // shared 33x32 multiplier operands
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      neg_in = neg_ff;
      case (ctl.state)
         ST_MUL_ACT: begin
            if (ctl.cmd == CMD_APPLY) begin
               neg_in = sample_ff[31];
               mul_a  = sample_ff[31] ? 33'(-{sample_ff[31], sample_ff})
                                      : 33'({sample_ff[31], sample_ff});
               mul_b  = 32'(rd_data.gain);
            end else begin
               neg_in = diff[32];
               mul_a  = diff[32] ? 33'(-diff) : 33'(diff);
               mul_b  = alpha_ff;
            end
         end
         ST_MUL_ERR: begin
            neg_in = err[32];
            mul_a  = err[32] ? 33'(-err) : 33'(err);
            mul_b  = 32'(dt_ff);
         end
         ST_MUL_GAIN: begin
            neg_in = integ_ff[47];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      prod_in = prod_ff;
      case (ctl.state)
         ST_MUL_ACT, ST_MUL_ERR: prod_in = mul_a * mul_b;
         ST_MUL_GAIN:            prod_in = {17'd0, integ_mag} * {52'd0, TENTH_Q16};
         default:                prod_in = prod_ff;
      endcase
   end

   assign smooth_in = (ctl.state == ST_SMOOTH)
                      ? sat32({{18{rd_data.smoothed[31]}}, rd_data.smoothed} + q_s)
                      : smooth_ff;
   assign integ_in  = (ctl.state == ST_INTEG)
                      ? sat48({{2{rd_data.integral[47]}}, rd_data.integral} + q_s)
                      : integ_ff;

   // result of the item, taken when the sequencer finishes it
   always_comb begin
      ok_in     = 1'b0;
      scaled_in = '0;
      gain_in   = GAIN_ONE;
      case (ctl.cmd)
         CMD_UPDATE: begin
            if (ctl.chan_ok && !ctl.dt_zero) begin
               ok_in   = 1'b1;
               gain_in = g_new;
            end else if (ctl.chan_ok) begin
               gain_in = rd_data.gain;
            end
         end
         CMD_APPLY: begin
            if (ctl.chan_ok) begin
               ok_in     = 1'b1;
               gain_in   = rd_data.gain;
               scaled_in = sat32(q_s);
            end else begin
               scaled_in = sample_ff;
            end
         end
         CMD_RESET_CHAN: ok_in = ctl.chan_ok;
         CMD_RESET_ALL:  ok_in = 1'b1;
         default:        ok_in = 1'b0;
      endcase
   end

   always_comb begin
      if (ctl.state == ST_CLEAR || ctl.cmd == CMD_RESET_CHAN) begin
         wr_data = ENTRY_RESET;
      end else begin
         wr_data = '{smoothed: smooth_ff, integral: integ_ff, gain: g_new};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         act_ff    <= req_activity;
         dt_ff     <= req_time_step;
         sample_ff <= req_sample_value;
      end
      if (ctl.state == ST_READ) begin
         alpha_ff <= alpha_full[47:16];
      end
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      smooth_ff <= smooth_in;
      integ_ff  <= integ_in;
      if (ctl.finish) begin
         ok_ff     <= ok_in;
         scaled_ff <= scaled_in;
         gain_ff   <= gain_in;
      end
   end

   assign rsp_ok           = ok_ff;
   assign rsp_scaled_value = scaled_ff;
   assign rsp_gain         = gain_ff;

endmodule

[sv/hgr_ctrl.sv]
// Sequencer: accepts a beat, steps the read-modify-write of one channel,
// runs the clearing sweep and owns the result valid. Depends on hgr_pkg.
module hgr_ctrl import hgr_pkg::*; #(
   parameter int CHAN_DEPTH = HGR_CHAN_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [DT_W-1:0]       req_time_step,
   input  logic [ACTIVE_W-1:0]   active_channels,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output hgr_ctl_type           ctl,
   output logic                  tbl_we,
   output logic [((CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1)-1:0] tbl_waddr,
   output logic [((CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1)-1:0] tbl_raddr
);

   localparam int IDX_W = (CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHAN_DEPTH - 1);

   hgr_state_type    state_ff, state_in;
   hgr_cmd_type      cmd_ff, cmd_in, req_cmd;
   logic             chan_ok_ff, chan_ok_in, dtz_ff, dtz_in;
   logic [IDX_W-1:0] idx_ff, idx_in, clr_cnt_ff, clr_cnt_in;
   logic             clr_reply_ff, clr_reply_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, finish_go, req_chan_ok, req_dt_zero;

   assign req_cmd     = hgr_cmd_type'(req_command);
   assign req_chan_ok = ({1'b0, req_channel} < active_channels)
                        && (int'(req_channel) < CHAN_DEPTH);
   assign req_dt_zero = (req_time_step == '0);
   assign accept      = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_UPDATE, CMD_APPLY: state_in = req_chan_ok ? ST_READ : ST_FINISH;
                  CMD_RESET_CHAN:        state_in = ST_FINISH;
                  CMD_RESET_ALL:         state_in = ST_CLEAR;
                  default:               state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ:     state_in = ST_MUL_ACT;
         ST_MUL_ACT:  state_in = (cmd_ff == CMD_UPDATE && !dtz_ff) ? ST_SMOOTH : ST_FINISH;
         ST_SMOOTH:   state_in = ST_MUL_ERR;
         ST_MUL_ERR:  state_in = ST_INTEG;
         ST_INTEG:    state_in = ST_MUL_GAIN;
         ST_MUL_GAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = clr_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath steering
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      finish_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
      tbl_we       = (state_ff == ST_CLEAR)
                     || (finish_go && chan_ok_ff
                         && (cmd_ff == CMD_RESET_CHAN
                             || (cmd_ff == CMD_UPDATE && !dtz_ff)));
      tbl_waddr    = (state_ff == ST_CLEAR) ? clr_cnt_ff : idx_ff;
      tbl_raddr    = idx_ff;
      rsp_valid_in = finish_go ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      ctl.state    = state_ff;
      ctl.cmd      = cmd_ff;
      ctl.chan_ok  = chan_ok_ff;
      ctl.dt_zero  = dtz_ff;
      ctl.accept   = accept;
      ctl.finish   = finish_go;
   end

   always_comb begin
      cmd_in       = accept ? req_cmd : cmd_ff;
      chan_ok_in   = accept ? req_chan_ok : chan_ok_ff;
      dtz_in       = accept ? req_dt_zero : dtz_ff;
      idx_in       = accept ? IDX_W'(req_channel) : idx_ff;
      clr_reply_in = accept ? 1'b1 : clr_reply_ff;
      if (accept) begin
         clr_cnt_in = '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end else begin
         clr_cnt_in = clr_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      chan_ok_ff <= chan_ok_in;
      dtz_ff     <= dtz_in;
      idx_ff     <= idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[sv/homeostatic_gain_regulator_unit.sv]
// Top level of the homeostatic gain regulator: csr registers, sequencer,
// datapath and channel memory. Depends on hgr_pkg, hgr_table, hgr_arith, hgr_ctrl.
//
// Usage
//   req channel: one beat per command (update, apply, reset channel, reset all).
//   rsp channel: exactly one beat per command, in order; tuser carries ok.
//   csr port: target level, reciprocal time constant, active channel count;
//   write only while no command is in flight.
// Sequencing (one command in flight, the next accepted once it leaves finish;
// channel memory and a shared 33x32 multiplier; states stepped after accept):
//   update with nonzero dt  read, mul_act, smooth, mul_err, integ, mul_gain, finish
//   update with zero dt, apply on a valid channel  read, mul_act, finish
//   invalid channel, reset channel  finish
//   reset all  clearing sweep over every entry, then finish
// Reset: csr registers take their defaults, then a clearing sweep writes every
//   memory entry with req_tready low, no rsp beat.
// Stall: the result sits in an output register; the next command is taken
//   while it waits, and a second result holds in its last step until the
//   first beat is taken.
module homeostatic_gain_regulator_unit import hgr_pkg::*; #(
   parameter int CHAN_DEPTH = HGR_CHAN_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: channel[5:0], activity[37:6], time_step[61:38],
   //            sample_value[93:62], zero pad[95:94]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,   // command[1:0]
   // rsp_tdata: scaled_value[31:0], gain[51:32], zero pad[55:52]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]             rsp_tuser,   // ok[0]
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1;

   logic signed [DATA_W-1:0] target_ff, target_in;
   logic [ITC_W-1:0]         inv_tau_ff, inv_tau_in;
   logic [ACTIVE_W-1:0]      active_ff, active_in;

   hgr_ctl_type              ctl;
   logic                     tbl_we;
   logic [IDX_W-1:0]         tbl_waddr, tbl_raddr;
   hgr_entry_type            tbl_wdata, tbl_rdata;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_scaled;
   logic [GAIN_W-1:0]        rsp_gain;

   // csr registers
   always_comb begin
      target_in  = target_ff;
      inv_tau_in = inv_tau_ff;
      active_in  = active_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_LEVEL: target_in  = csr_wdata;
            CSR_INV_TAU:      inv_tau_in = csr_wdata[ITC_W-1:0];
            CSR_ACTIVE_CHANS: active_in  = csr_wdata[ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         inv_tau_ff <= ITC_RESET;
         active_ff  <= ACTIVE_RESET;
      end else begin
         target_ff  <= target_in;
         inv_tau_ff <= inv_tau_in;
         active_ff  <= active_in;
      end
   end

   hgr_ctrl #(.CHAN_DEPTH(CHAN_DEPTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_command     (req_tuser),
      .req_channel     (req_tdata[5:0]),
      .req_time_step   (req_tdata[61:38]),
      .active_channels (active_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .ctl             (ctl),
      .tbl_we          (tbl_we),
      .tbl_waddr       (tbl_waddr),
      .tbl_raddr       (tbl_raddr)
   );

   hgr_arith u_arith (
      .clock            (clock),
      .ctl              (ctl),
      .req_activity     (req_tdata[37:6]),
      .req_time_step    (req_tdata[61:38]),
      .req_sample_value (req_tdata[93:62]),
      .target_level     (target_ff),
      .inv_tau          (inv_tau_ff),
      .rd_data          (tbl_rdata),
      .wr_data          (tbl_wdata),
      .rsp_ok           (rsp_ok),
      .rsp_scaled_value (rsp_scaled),
      .rsp_gain         (rsp_gain)
   );

   hgr_table #(.CHAN_DEPTH(CHAN_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign rsp_tdata = {4'd0, rsp_gain, rsp_scaled};
   assign rsp_tuser = rsp_ok;

   // one command at a time: ready drops right after a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req beat taken while a command is in flight");

   // memory writes only from the clearing sweep or the finishing step
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (ctl.state == ST_CLEAR || ctl.state == ST_FINISH))
      else $error("channel memory written outside sweep or finish");

   // a successful result always carries a gain inside the clamp range
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_gain >= GAIN_MIN && rsp_gain <= GAIN_MAX))
      else $error("rsp gain outside clamp range");

endmodule
